[sv/led_flash_pattern_controller_unit_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the LED flash pattern controller
// Concurrent assertion wrappers that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LED_FLASH_PATTERN_CONTROLLER_UNIT_MACROS_SVH
`define LED_FLASH_PATTERN_CONTROLLER_UNIT_MACROS_SVH

`ifndef SYNTH
`define LFPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define LFPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define LFPC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg)
`define LFPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[sv/lfpc_pkg.sv]
// ----------------------------------------------------------------------------
// LED flash pattern controller package
// Codes, item types and scaling constants shared by the controller files.
// ----------------------------------------------------------------------------
package lfpc_pkg;

  localparam int TS_W    = 32;
  localparam int COLOR_W = 3;
  localparam int CMD_W   = 2;
  localparam int PHASE_W = 3;
  localparam int LEVEL_W = 8;

  localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ONCE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CONT = 2'd3;

  localparam logic [COLOR_W-1:0] COLOR_OFF    = 3'd0;
  localparam logic [COLOR_W-1:0] COLOR_RED    = 3'd1;
  localparam logic [COLOR_W-1:0] COLOR_GREEN  = 3'd2;
  localparam logic [COLOR_W-1:0] COLOR_BLUE   = 3'd3;
  localparam logic [COLOR_W-1:0] COLOR_WHITE  = 3'd4;
  localparam logic [COLOR_W-1:0] COLOR_YELLOW = 3'd5;

  localparam logic [PHASE_W-1:0] PH_STEADY = 3'd0;
  localparam logic [PHASE_W-1:0] PH_ONCE_1 = 3'd1;
  localparam logic [PHASE_W-1:0] PH_ONCE_2 = 3'd2;
  localparam logic [PHASE_W-1:0] PH_ONCE_3 = 3'd3;
  localparam logic [PHASE_W-1:0] PH_ONCE_4 = 3'd4;
  localparam logic [PHASE_W-1:0] PH_CONT_1 = 3'd5;
  localparam logic [PHASE_W-1:0] PH_CONT_2 = 3'd6;

  localparam logic REG_INTERVAL   = 1'b0;
  localparam logic REG_BRIGHTNESS = 1'b1;

  localparam logic [TS_W-1:0]    INTERVAL_RST   = 32'd200;
  localparam logic [LEVEL_W-1:0] BRIGHTNESS_RST = 8'd64;

  // Fixed-point reciprocal scaling: floor(B * K / 2^SCALE_SH) matches the
  // decimal floor for every 8-bit brightness.
  localparam int SCALE_SH = 20;
  localparam int PROD_W   = LEVEL_W + SCALE_SH;
  localparam logic [PROD_W-1:0] RED_R_K = 28'd1019216;
  localparam logic [PROD_W-1:0] RED_G_K = 28'd743441;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [COLOR_W-1:0] first_color;
    logic [COLOR_W-1:0] second_color;
    logic [TS_W-1:0]    timestamp;
  } item_t;

  typedef struct packed {
    logic [COLOR_W-1:0] shown_color;
    logic [PHASE_W-1:0] phase;
  } view_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] red;
    logic [LEVEL_W-1:0] green;
    logic [LEVEL_W-1:0] blue;
  } levels_t;

  function automatic logic color_known(input logic [COLOR_W-1:0] code);
    return code <= COLOR_YELLOW;
  endfunction

endpackage

[sv/lfpc_in_if.sv]
// ----------------------------------------------------------------------------
// Command channel interface
// Valid/ready channel carrying one command item per transfer.
// ----------------------------------------------------------------------------
interface lfpc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [2:0]  first_color;
  logic [2:0]  second_color;
  logic [31:0] timestamp;

  modport source (output valid, command, first_color, second_color, timestamp,
                  input ready);
  modport sink (input valid, command, first_color, second_color, timestamp,
                output ready);
endinterface

[sv/lfpc_out_if.sv]
// ----------------------------------------------------------------------------
// Level channel interface
// Valid/ready channel carrying one RGB level set and phase per transfer.
// ----------------------------------------------------------------------------
interface lfpc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;
  logic [2:0] pattern_phase;

  modport source (output valid, red_level, green_level, blue_level, pattern_phase,
                  input ready);
  modport sink (input valid, red_level, green_level, blue_level, pattern_phase,
                output ready);
endinterface

[sv/lfpc_levels.sv]
// ----------------------------------------------------------------------------
// Color level table
// Maps a color code and brightness to red, green and blue levels.
// ----------------------------------------------------------------------------
module lfpc_levels (
  input  logic [lfpc_pkg::COLOR_W-1:0] code,
  input  logic [lfpc_pkg::LEVEL_W-1:0] brightness,
  output lfpc_pkg::levels_t            levels
);
  import lfpc_pkg::*;

  logic [PROD_W-1:0] red_r_prod;
  logic [PROD_W-1:0] red_g_prod;

  assign red_r_prod = {{SCALE_SH{1'b0}}, brightness} * RED_R_K;
  assign red_g_prod = {{SCALE_SH{1'b0}}, brightness} * RED_G_K;

  always_comb begin
    levels = '0;
    case (code)
      COLOR_RED: begin
        levels.red   = red_r_prod[PROD_W-1:SCALE_SH];
        levels.green = red_g_prod[PROD_W-1:SCALE_SH];
      end
      COLOR_GREEN: begin
        levels.green = brightness;
      end
      COLOR_BLUE: begin
        levels.blue = brightness;
      end
      COLOR_WHITE: begin
        levels.red   = brightness;
        levels.green = brightness;
        levels.blue  = brightness;
      end
      COLOR_YELLOW: begin
        levels.red   = brightness;
        levels.green = brightness;
      end
      default: begin
        levels = '0;
      end
    endcase
  end

endmodule

[sv/lfpc_seq.sv]
// ----------------------------------------------------------------------------
// Flash pattern sequencer
// Holds the pattern state and applies one command and timer check per step.
// ----------------------------------------------------------------------------
`include "led_flash_pattern_controller_unit_macros.svh"

module lfpc_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  lfpc_pkg::item_t           item,
  input  logic [lfpc_pkg::TS_W-1:0] interval,
  output lfpc_pkg::view_t           view
);
  import lfpc_pkg::*;

  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [COLOR_W-1:0] steady_r, steady_nxt;
  logic [COLOR_W-1:0] first_r, first_nxt;
  logic [COLOR_W-1:0] second_r, second_nxt;
  logic [COLOR_W-1:0] shown_r, shown_nxt;
  logic [TS_W-1:0]    start_r, start_nxt;
  logic [TS_W-1:0]    elapsed;
  logic               due;

  always_comb begin
    phase_nxt  = phase_r;
    steady_nxt = steady_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    shown_nxt  = shown_r;
    start_nxt  = start_r;

    case (item.command)
      CMD_SET: begin
        steady_nxt = item.first_color;
        phase_nxt  = PH_STEADY;
        if (color_known(item.first_color)) shown_nxt = item.first_color;
      end
      CMD_ONCE, CMD_CONT: begin
        first_nxt  = item.first_color;
        second_nxt = item.second_color;
        phase_nxt  = (item.command == CMD_ONCE) ? PH_ONCE_1 : PH_CONT_1;
        if (color_known(item.first_color)) shown_nxt = item.first_color;
        start_nxt  = item.timestamp;
      end
      default: begin
      end
    endcase

    elapsed = item.timestamp - start_nxt;
    due     = elapsed > interval;

    if (due) begin
      case (phase_nxt)
        PH_ONCE_1, PH_ONCE_3, PH_CONT_1: begin
          phase_nxt = (phase_nxt == PH_CONT_1) ? PH_CONT_2 : phase_nxt + 3'd1;
          if (color_known(second_nxt)) shown_nxt = second_nxt;
          start_nxt = item.timestamp;
        end
        PH_ONCE_2, PH_CONT_2: begin
          phase_nxt = (phase_nxt == PH_CONT_2) ? PH_CONT_1 : PH_ONCE_3;
          if (color_known(first_nxt)) shown_nxt = first_nxt;
          start_nxt = item.timestamp;
        end
        PH_ONCE_4: begin
          phase_nxt = PH_STEADY;
          if (color_known(steady_nxt)) shown_nxt = steady_nxt;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_STEADY;
      steady_r <= COLOR_OFF;
      first_r  <= COLOR_OFF;
      second_r <= COLOR_OFF;
      shown_r  <= COLOR_OFF;
      start_r  <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      steady_r <= steady_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      shown_r  <= shown_nxt;
      start_r  <= start_nxt;
    end
  end

  assign view.shown_color = shown_nxt;
  assign view.phase       = phase_nxt;

  `LFPC_ASSERT_NEXT(a_once_starts, clk, rst_n, step && item.command == CMD_ONCE,
                    phase_r == PH_ONCE_1, "flash once did not start in its first phase")
  `LFPC_ASSERT_NEXT(a_cont_starts, clk, rst_n, step && item.command == CMD_CONT,
                    phase_r == PH_CONT_1, "continuous flash did not start in its first phase")
  `LFPC_ASSERT_NEXT(a_flash_stamp, clk, rst_n,
                    step && (item.command == CMD_ONCE || item.command == CMD_CONT),
                    start_r == $past(item.timestamp), "flash start time not captured")
  `LFPC_ASSERT_NEXT(a_set_steady, clk, rst_n, step && item.command == CMD_SET,
                    phase_r == PH_STEADY && steady_r == $past(item.first_color),
                    "set color did not return to steady")

endmodule

[sv/led_flash_pattern_controller_unit.sv]
// ----------------------------------------------------------------------------
// LED flash pattern controller
// Turns timestamped color and flash commands into RGB levels and a phase.
//
//   Channel   Role    Transfer contents
//   in_ch     sink    command, first_color, second_color, timestamp
//   out_ch    source  red_level, green_level, blue_level, pattern_phase
//   cfg_*     write   index 0 phase interval, index 1 brightness
//
// One item per cycle sustained while the result is not stalled. An input
// transfer loads the input register; the result register loads from it when
// the item fires. The pattern state updates with each fired item.
// Reset is synchronous; no clearing pass.
// A stalled result holds the item in the input register, and input ready
// drops only when both registers are full.
// ----------------------------------------------------------------------------
module led_flash_pattern_controller_unit (
  input  logic        clk,
  input  logic        rst_n,
  lfpc_in_if.sink     in_ch,
  lfpc_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import lfpc_pkg::*;

  logic [TS_W-1:0]    interval_r;
  logic [LEVEL_W-1:0] brightness_r;
  logic               in_valid_r;
  item_t              item_r;
  logic               out_valid_r;
  levels_t            levels_r;
  logic [PHASE_W-1:0] phase_out_r;
  logic               fire;
  view_t              view;
  levels_t            levels;

  assign fire        = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r   <= INTERVAL_RST;
      brightness_r <= BRIGHTNESS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_INTERVAL:   interval_r   <= cfg_data;
        REG_BRIGHTNESS: brightness_r <= cfg_data[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.command      <= in_ch.command;
      item_r.first_color  <= in_ch.first_color;
      item_r.second_color <= in_ch.second_color;
      item_r.timestamp    <= in_ch.timestamp;
    end
  end

  lfpc_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .step     (fire),
    .item     (item_r),
    .interval (interval_r),
    .view     (view)
  );

  lfpc_levels u_levels (
    .code       (view.shown_color),
    .brightness (brightness_r),
    .levels     (levels)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      levels_r    <= levels;
      phase_out_r <= view.phase;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.red_level     = levels_r.red;
  assign out_ch.green_level   = levels_r.green;
  assign out_ch.blue_level    = levels_r.blue;
  assign out_ch.pattern_phase = phase_out_r;

endmodule
